[rtl/hec_pkg.sv]
// Shared constants, types and the check-matrix table for the Hamming encoder and corrector.
`timescale 1ns / 1ps

package hec_pkg;

    // Code size follows from the number of parity bits.
    localparam int PARITY_BITS = 3;
    localparam int CODE_LEN    = (1 << PARITY_BITS) - 1;
    localparam int DATA_LEN    = CODE_LEN - PARITY_BITS;

    // Widths of the fields carried on the ports.
    localparam int WORD_W        = 7;
    localparam int SYN_W         = 3;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 16;
    localparam int OUT_TDATA_PAD = OUT_TDATA_W - WORD_W - SYN_W;

    typedef logic [PARITY_BITS-1:0] t_col;
    typedef t_col [CODE_LEN-1:0]    t_col_tab;

    // Request kinds carried in the input tuser.
    typedef enum logic {
        REQ_ENCODE  = 1'b0,
        REQ_CORRECT = 1'b1
    } t_req;

    // One result word.
    typedef struct packed {
        logic [WORD_W-1:0] word_out;
        logic [SYN_W-1:0]  syndrome;
        logic              bit_flipped;
    } t_result;

    // Column j starts as CODE_LEN-j; the power-of-two columns are then
    // swapped to the front so that the parity bits sit in the lowest positions.
    function automatic t_col_tab build_cols();
        t_col_tab tab;
        t_col     tmp;
        int       idx;
        for (int j = 0; j < CODE_LEN; j++) begin
            tab[j] = t_col'(CODE_LEN - j);
        end
        for (int i = 0; i < PARITY_BITS; i++) begin
            idx      = CODE_LEN - (1 << (PARITY_BITS - 1 - i));
            tmp      = tab[i];
            tab[i]   = tab[idx];
            tab[idx] = tmp;
        end
        return tab;
    endfunction

    localparam t_col_tab COLS = build_cols();

endpackage

[rtl/hec_core.sv]
// Combinational encode and single-error correction of one word.
`timescale 1ns / 1ps

module hec_core
    import hec_pkg::*;
(
    input  t_req              i_req,
    input  logic [WORD_W-1:0] i_data,
    output t_result           o_res
);

    logic [DATA_LEN-1:0] data;
    logic [CODE_LEN-1:0] enc_word;
    t_col                acc;
    logic [CODE_LEN-1:0] rx_word;
    t_col                syn;
    logic [CODE_LEN-1:0] fix_mask;

    // Encoder: data bits go above the parity bits, parity is the XOR of
    // the columns of the set data bits.
    always_comb begin
        data     = DATA_LEN'(i_data);
        acc      = '0;
        enc_word = '0;
        for (int i = 0; i < DATA_LEN; i++) begin
            enc_word[PARITY_BITS+i] = data[i];
            if (data[i]) begin
                acc = acc ^ COLS[PARITY_BITS+i];
            end
        end
        for (int i = 0; i < PARITY_BITS; i++) begin
            enc_word[i] = acc[PARITY_BITS-1-i];
        end
    end

    // Syndrome of the received word, then a one-hot mask of the matching
    // column. The columns are all distinct and nonzero, so at most one matches.
    always_comb begin
        rx_word  = CODE_LEN'(i_data);
        syn      = '0;
        fix_mask = '0;
        for (int p = 0; p < CODE_LEN; p++) begin
            if (rx_word[p]) begin
                syn = syn ^ COLS[p];
            end
        end
        for (int p = 0; p < CODE_LEN; p++) begin
            fix_mask[p] = (syn != '0) && (COLS[p] == syn);
        end
    end

    // Select the result for the request kind.
    always_comb begin
        unique case (i_req)
            REQ_ENCODE: begin
                o_res.word_out    = WORD_W'(enc_word);
                o_res.syndrome    = '0;
                o_res.bit_flipped = 1'b0;
            end
            REQ_CORRECT: begin
                o_res.word_out    = WORD_W'(rx_word ^ fix_mask);
                o_res.syndrome    = SYN_W'(syn);
                o_res.bit_flipped = |syn;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

[rtl/hamming_encode_correct.sv]
// Top level: input register, encode/correct logic and output register.
//
// Hamming single-error-correcting code, (7,4) with three parity bits.
// Slave channel: tuser[0] selects the request (0 encode, 1 check and
// correct), tdata[6:0] holds the data bits (encode, low bits) or the
// received codeword (correct). Master channel: one result word per input
// word, tdata holds the codeword and the syndrome, tuser[0] is set when a
// bit was flipped.
// The result is offered once the word has passed from the input register,
// with the XOR trees and the column compare behind it, into the output
// register, where it is held until taken. A new word is accepted in
// every cycle while the receiver keeps taking results.
// Reset clears both valid flags; no result is offered after reset until
// a word arrives. When the receiver stalls, the result holds in the output
// register and one more word waits in the input register; tready falls
// only once both are full.
`timescale 1ns / 1ps

module hamming_encode_correct
    import hec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Slave side
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [6:0] data_in, [7] zero
    input  logic [0:0]             i_s_tuser,   // [0] req_type
    // Master side
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [6:0] word_out, [9:7] syndrome, [15:10] zero
    output logic [0:0]             o_m_tuser    // [0] bit_flipped
);

    logic              r_in_valid;
    t_req              r_req;
    logic [WORD_W-1:0] r_data;
    logic              r_out_valid;
    t_result           r_res;
    t_result           core_res;
    logic              out_ready;
    logic              in_ready;

    // Each stage may load when it is empty or its contents move on.
    assign out_ready  = !r_out_valid || i_m_tready;
    assign in_ready   = !r_in_valid || out_ready;
    assign o_s_tready = in_ready;

    // Valid flags of both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_tvalid) begin
            r_req  <= t_req'(i_s_tuser[0]);
            r_data <= i_s_tdata[WORD_W-1:0];
        end
    end

    hec_core u_core (
        .i_req  (r_req),
        .i_data (r_data),
        .o_res  (core_res)
    );

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (out_ready && r_in_valid) begin
            r_res <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{OUT_TDATA_PAD{1'b0}}, r_res.syndrome, r_res.word_out};
    assign o_m_tuser  = r_res.bit_flipped;

endmodule
